// ----- src/irpd_pkg.sv -----
// Package: shared constants, types and register codes of the IR pulse-distance decoder.
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BITPOS_W = 3;
  localparam int unsigned BCOUNT_W = 6;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [BCOUNT_W-1:0] MAX_BYTES = 6'd32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [COUNT_W-1:0] LEADER_MIN_RST = 16'd3400;
  localparam logic [COUNT_W-1:0] ONE_MIN_RST = 16'd1000;
  localparam logic [COUNT_W-1:0] END_MIN_RST = 16'd10000;

  typedef enum logic [1:0] {
    REG_LEADER_MIN = 2'd0,
    REG_ONE_MIN    = 2'd1,
    REG_END_MIN    = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_LEADER       = 3'd1,
    PH_LEADER_SPACE = 3'd2,
    PH_MARK         = 3'd3,
    PH_SPACE        = 3'd4
  } phase_e;

  typedef struct packed {
    logic [COUNT_W-1:0] leader_min;
    logic [COUNT_W-1:0] one_min;
    logic [COUNT_W-1:0] end_min;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic                byte_valid;
    logic                frame_end;
    logic [BCOUNT_W-1:0] byte_count;
    logic                overflow;
  } res_t;

endpackage

// ----- src/irpd_if.sv -----
// Interfaces: the sample channel and the result channel of the decoder.
`timescale 1ns / 1ps

interface irpd_in_if;
  logic valid;
  logic ready;
  logic ir_level;

  modport source (output valid, output ir_level, input ready);
  modport sink (input valid, input ir_level, output ready);
endinterface

interface irpd_out_if;
  logic                               valid;
  logic                               ready;
  logic [irpd_pkg::BYTE_W-1:0]        data_byte;
  logic                               byte_valid;
  logic                               frame_end;
  logic [irpd_pkg::BCOUNT_W-1:0]      byte_count;
  logic                               overflow;

  modport source (output valid, output data_byte, output byte_valid, output frame_end,
                  output byte_count, output overflow, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input frame_end,
                input byte_count, input overflow, output ready);
endinterface

// ----- src/irpd_cfg_regs.sv -----
// Threshold registers behind the APB-style configuration port.
`timescale 1ns / 1ps

module irpd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpd_pkg::APB_AW-1:0]   paddr,
  input  logic [irpd_pkg::APB_DW-1:0]   pwdata,
  output logic [irpd_pkg::APB_DW-1:0]   prdata,
  output irpd_pkg::cfg_t                cfg_o
);
  import irpd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_min <= LEADER_MIN_RST;
      cfg_q.one_min    <= ONE_MIN_RST;
      cfg_q.end_min    <= END_MIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEADER_MIN: cfg_q.leader_min <= pwdata[COUNT_W-1:0];
        REG_ONE_MIN:    cfg_q.one_min    <= pwdata[COUNT_W-1:0];
        REG_END_MIN:    cfg_q.end_min    <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEADER_MIN: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_q.leader_min};
      REG_ONE_MIN:    prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_q.one_min};
      REG_END_MIN:    prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_q.end_min};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/irpd_core.sv -----
// Decoder core: sample register, pulse timing state machine and result register.
`timescale 1ns / 1ps

module irpd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  irpd_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  input  logic            in_level_i,
  output logic            in_ready_o,
  output logic            res_valid_o,
  output irpd_pkg::res_t  res_o,
  input  logic            res_ready_i
);
  import irpd_pkg::*;

  // Sample register
  logic in_valid_q;
  logic in_level_q;

  // Decoder state
  phase_e               phase_q, phase_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;
  logic [BYTE_W-1:0]    shift_q, shift_d;
  logic [BITPOS_W-1:0]  pos_q, pos_d;
  logic [BCOUNT_W-1:0]  bytes_q, bytes_d;
  logic                 ovf_q, ovf_d;

  // Result register
  logic res_valid_q;
  res_t res_q, res_d;

  logic               emit;
  logic               advance;
  logic               high;
  logic [COUNT_W-1:0] cnt_inc;
  logic               leader_ok;
  logic               run_end;
  logic               stop_end;
  logic               mark_end;
  logic               is_one;
  logic [BYTE_W-1:0]  shift_set;
  logic [BITPOS_W-1:0] pos_inc;

  assign high      = in_level_q;
  assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign leader_ok = cnt_q >= cfg_i.leader_min;
  assign run_end   = cnt_inc >= cfg_i.end_min;
  assign stop_end  = cnt_q >= cfg_i.end_min;
  assign mark_end  = cfg_i.end_min <= {{(COUNT_W-1){1'b0}}, 1'b1};
  assign is_one    = cnt_q >= cfg_i.one_min;
  assign shift_set = is_one ? (shift_q | (BYTE_W'(1) << pos_q)) : shift_q;
  assign pos_inc   = pos_q + 1'b1;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_LEADER: begin
        if (high) begin
          phase_d = leader_ok ? PH_LEADER_SPACE : PH_IDLE;
        end
      end
      PH_LEADER_SPACE: begin
        if (!high) begin
          phase_d = PH_MARK;
        end
      end
      PH_MARK: begin
        if (high) begin
          phase_d = mark_end ? PH_IDLE : PH_SPACE;
        end
      end
      PH_SPACE: begin
        if (high) begin
          phase_d = run_end ? PH_IDLE : PH_SPACE;
        end else begin
          phase_d = stop_end ? PH_IDLE : PH_MARK;
        end
      end
      default: begin
        phase_d = high ? PH_IDLE : PH_LEADER;
      end
    endcase
  end

  // Datapath and result
  always_comb begin
    cnt_d   = cnt_q;
    shift_d = shift_q;
    pos_d   = pos_q;
    bytes_d = bytes_q;
    ovf_d   = ovf_q;
    emit    = 1'b0;
    res_d   = '0;
    unique case (phase_q)
      PH_LEADER: begin
        if (!high) begin
          cnt_d = cnt_inc;
        end else if (leader_ok) begin
          cnt_d   = '0;
          shift_d = '0;
          pos_d   = '0;
          bytes_d = '0;
          ovf_d   = 1'b0;
        end else begin
          cnt_d = '0;
        end
      end
      PH_LEADER_SPACE: ;
      PH_MARK: begin
        if (high) begin
          if (mark_end) begin
            cnt_d   = '0;
            shift_d = '0;
            pos_d   = '0;
            emit    = 1'b1;
          end else begin
            cnt_d = {{(COUNT_W-1){1'b0}}, 1'b1};
          end
        end
      end
      PH_SPACE: begin
        if ((high && run_end) || (!high && stop_end)) begin
          cnt_d   = '0;
          shift_d = '0;
          pos_d   = '0;
          emit    = 1'b1;
        end else if (high) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d   = '0;
          pos_d   = pos_inc;
          shift_d = shift_set;
          if (pos_inc == '0) begin
            shift_d = '0;
            if (bytes_q < MAX_BYTES) begin
              bytes_d         = bytes_q + 1'b1;
              emit            = 1'b1;
              res_d.data_byte = shift_set;
              res_d.byte_valid = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!high) begin
          cnt_d = {{(COUNT_W-1){1'b0}}, 1'b1};
        end
      end
    endcase
    res_d.frame_end  = emit && !res_d.byte_valid;
    res_d.byte_count = bytes_d;
    res_d.overflow   = ovf_d;
  end

  // A sample that yields no result moves on even while the result waits.
  assign advance    = in_valid_q && (!res_valid_q || res_ready_i || !emit);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      shift_q     <= '0;
      pos_q       <= '0;
      bytes_q     <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        pos_q   <= pos_d;
        bytes_q <= bytes_d;
        ovf_q   <= ovf_d;
        if (emit) begin
          res_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_level_q <= in_level_i;
    end
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.byte_valid != res_q.frame_end))
    else $error("result is neither a single byte nor a single frame end");

  a_bytes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= MAX_BYTES)
    else $error("frame byte count beyond its limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (bytes_q == MAX_BYTES))
    else $error("overflow flagged while the frame still had room");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> (phase_q == PH_MARK || phase_q == PH_SPACE))
    else $error("partial byte held outside a frame");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> res_valid_q)
    else $error("pending result lost before it was taken");

endmodule

// ----- src/ir_pulse_distance_decoder.sv -----
// Top level of the IR pulse-distance decoder: configuration registers and decoder core.
`timescale 1ns / 1ps

// The block decodes an active-low IR receiver line sampled once per microsecond tick.
// Each word on the input channel carries one pin sample; each word on the output
// channel is either a completed byte (first received bit in bit 0) or a frame-end
// marker carrying the frame's byte count and overflow flag.
// Both channels use valid/ready; a word moves on a clock edge with both high.
// Thresholds for the leader, the one-bit space and the frame end are written through
// the APB-style port at byte addresses 0, 4 and 8; the user is to write them only while
// the block is idle, as the block itself does not enforce it. A sample is captured in
// the input register and its result, if any, is then registered in the result register
// that drives the output word; a held word can stall that step.
// Throughput: one sample per cycle while no held result word blocks the input, with a
// single state update per sample in the timing state machine.
// Reset clears the decoder to the idle phase with empty counters and restores
// the default thresholds (3400, 1000 and 10000 ticks).
// When the receiver stalls, the result word is held; samples that produce no
// word keep flowing, and the first sample that would produce another word waits
// in the input register, dropping input ready until the held word is taken.
module ir_pulse_distance_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  irpd_in_if.sink                       in_i,
  irpd_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpd_pkg::APB_AW-1:0]   paddr,
  input  logic [irpd_pkg::APB_DW-1:0]   pwdata,
  output logic [irpd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import irpd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;

  // The register file answers every access in its first access cycle.
  assign pready = 1'b1;

  irpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  irpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_level_i  (in_i.ir_level),
    .in_ready_o  (in_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (out_o.ready)
  );

  // Unpack the registered result onto the output word.
  assign out_o.valid      = res_valid;
  assign out_o.data_byte  = res.data_byte;
  assign out_o.byte_valid = res.byte_valid;
  assign out_o.frame_end  = res.frame_end;
  assign out_o.byte_count = res.byte_count;
  assign out_o.overflow   = res.overflow;

endmodule

// ----- test/irpd_frame_checker.sv -----
// Checker for the IR pulse-distance decoder: predicts output words and compares them.
`timescale 1ns / 1ps

module irpd_frame_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  irpd_in_if                          samples_i,
  irpd_out_if                         words_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [irpd_pkg::APB_AW-1:0] paddr_i,
  input  logic [irpd_pkg::APB_DW-1:0] pwdata_i,
  input  logic                        pready_i,
  output int                          mismatches_o,
  output int                          pending_o
);
  import irpd_pkg::*;

  cfg_t                thresholds;
  phase_e              phase_q;
  logic [COUNT_W-1:0]  ticks_q;
  logic [BYTE_W-1:0]   shift_q;
  logic [BITPOS_W-1:0] bitpos_q;
  logic [BCOUNT_W-1:0] bytes_q;
  logic                overflow_q;
  res_t                expected_words[$];
  int                  mismatches;

  task automatic push_word(input logic [BYTE_W-1:0] data, input logic is_byte);
    res_t w;
    w.data_byte  = data;
    w.byte_valid = is_byte;
    w.frame_end  = !is_byte;
    w.byte_count = bytes_q;
    w.overflow   = overflow_q;
    expected_words.push_back(w);
  endtask

  // The frame closes: any partial byte is thrown away, the frame totals are kept.
  task automatic close_frame();
    phase_q  = PH_IDLE;
    ticks_q  = '0;
    shift_q  = '0;
    bitpos_q = '0;
    push_word('0, 1'b0);
  endtask

  task automatic decode_sample(input logic high);
    logic [BYTE_W-1:0] done;
    case (phase_q)
      PH_LEADER: begin
        if (!high) begin
          if (ticks_q != COUNT_MAX) ticks_q = ticks_q + 1'b1;
        end else if (ticks_q >= thresholds.leader_min) begin
          phase_q    = PH_LEADER_SPACE;
          ticks_q    = '0;
          shift_q    = '0;
          bitpos_q   = '0;
          bytes_q    = '0;
          overflow_q = 1'b0;
        end else begin
          phase_q = PH_IDLE;
          ticks_q = '0;
        end
      end
      PH_LEADER_SPACE: begin
        if (!high) phase_q = PH_MARK;
      end
      PH_MARK: begin
        if (high) begin
          phase_q = PH_SPACE;
          ticks_q = 16'd1;
          if (ticks_q >= thresholds.end_min) close_frame();
        end
      end
      PH_SPACE: begin
        if (high) begin
          if (ticks_q != COUNT_MAX) ticks_q = ticks_q + 1'b1;
          if (ticks_q >= thresholds.end_min) close_frame();
        end else if (ticks_q >= thresholds.end_min) begin
          // The end threshold was lowered while this space was running.
          close_frame();
        end else begin
          if (ticks_q >= thresholds.one_min) shift_q[bitpos_q] = 1'b1;
          bitpos_q = bitpos_q + 1'b1;
          phase_q  = PH_MARK;
          ticks_q  = '0;
          if (bitpos_q == 0) begin
            done    = shift_q;
            shift_q = '0;
            if (bytes_q < MAX_BYTES) begin
              bytes_q = bytes_q + 1'b1;
              push_word(done, 1'b1);
            end else begin
              overflow_q = 1'b1;
            end
          end
        end
      end
      default: begin
        phase_q = PH_IDLE;
        if (!high) begin
          phase_q = PH_LEADER;
          ticks_q = 16'd1;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    res_t  got;
    res_t  want;
    string diff;
    if (!rst_ni) begin
      thresholds = '{leader_min: LEADER_MIN_RST, one_min: ONE_MIN_RST, end_min: END_MIN_RST};
      phase_q    = PH_IDLE;
      ticks_q    = '0;
      shift_q    = '0;
      bitpos_q   = '0;
      bytes_q    = '0;
      overflow_q = 1'b0;
      mismatches = 0;
      expected_words.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_LEADER_MIN: thresholds.leader_min = pwdata_i[COUNT_W-1:0];
          REG_ONE_MIN:    thresholds.one_min    = pwdata_i[COUNT_W-1:0];
          REG_END_MIN:    thresholds.end_min    = pwdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (samples_i.valid && samples_i.ready) decode_sample(samples_i.ir_level);
      if (words_i.valid && words_i.ready) begin
        got.data_byte  = words_i.data_byte;
        got.byte_valid = words_i.byte_valid;
        got.frame_end  = words_i.frame_end;
        got.byte_count = words_i.byte_count;
        got.overflow   = words_i.overflow;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: data %h byte %b end %b count %0d ovf %b", $time,
                   got.data_byte, got.byte_valid, got.frame_end, got.byte_count, got.overflow);
        end else begin
          want = expected_words.pop_front();
          diff = "";
          if (got.data_byte !== want.data_byte) diff = {diff, " data_byte"};
          if (got.byte_valid !== want.byte_valid) diff = {diff, " byte_valid"};
          if (got.frame_end !== want.frame_end) diff = {diff, " frame_end"};
          if (got.byte_count !== want.byte_count) diff = {diff, " byte_count"};
          if (got.overflow !== want.overflow) diff = {diff, " overflow"};
          if (diff != "") begin
            mismatches++;
            $display("%0t: word mismatch in%s", $time, diff);
            $display("  expected: data %h byte %b end %b count %0d ovf %b", want.data_byte,
                     want.byte_valid, want.frame_end, want.byte_count, want.overflow);
            $display("  actual:   data %h byte %b end %b count %0d ovf %b", got.data_byte,
                     got.byte_valid, got.frame_end, got.byte_count, got.overflow);
          end
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_words.size();
  end

endmodule

// ----- test/testbench.sv -----
// Testbench top: drives pin samples and register writes into the decoder and gives the verdict.
`timescale 1ns / 1ps

// The decoder takes one pin sample per word and answers with a word per completed byte
// and a word at every frame end. This top only makes stimulus: the checker beside the
// block watches both channels and the register port, predicts every output word and
// counts mismatches.
//
// The run goes through these stages:
//   - a leader far too short at the reset thresholds;
//   - small thresholds: the all-zero and all-one bytes on the boundaries, a leader one
//     tick too short, a frame cut off mid-byte, and a frame ended by lowering the end
//     threshold while a space is running;
//   - zero thresholds, where one low tick is a valid leader and the first space tick ends
//     the frame, and a zero bit threshold that reads every space as a one;
//   - a frame of more bytes than the block keeps, then a frame that shows the overflow
//     flag cleared again;
//   - all thresholds at their maximum, where a short leader leaves the block idle;
//   - random frames under random thresholds, mixed with noise, short leaders and frames
//     that break off part way through a byte.
module testbench;
  import irpd_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SAMPLE_TARGET   = 240;
  localparam int SETTLE_CYCLES   = 4;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  irpd_in_if  in_if ();
  irpd_out_if out_if ();

  int   mismatches;
  int   pending;
  int   tx_idle_pct     = 19;
  int   rx_idle_pct     = 55;
  int   hold_off_asked  = 0;
  int   hold_off_served = 0;
  int   samples_sent    = 0;
  int   quiet_cycles    = 0;
  // Thresholds as last written; used only to shape the frames that are sent.
  cfg_t shape_cfg;

  ir_pulse_distance_decoder i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  irpd_frame_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .samples_i    (in_if),
    .words_i      (out_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver takes words at random, except for one long hold-off that is asked for by
  // the stimulus. During that hold-off the sender keeps offering samples, so the block
  // ends up holding one word with the next one waiting and must stall its input.
  initial begin : receiver
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_asked != hold_off_served) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_served++;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: if nothing moves on either channel or the register port for too long, the
  // block has hung.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // One pin sample, with a random gap in front of it. The valid line stays high from one
  // sample to the next when no gap falls between them.
  task automatic send_sample(input logic level);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid    <= 1'b0;
      in_if.ir_level <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.ir_level <= level;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic send_run(input logic level, input int ticks);
    repeat (ticks) send_sample(level);
  endtask

  // Length of the space that encodes one bit. Tight spaces sit right on the boundary:
  // the longest zero and the shortest one.
  function automatic int space_ticks(input logic one, input bit tight);
    int lo;
    int hi;
    if (one) begin
      lo = (shape_cfg.one_min == 0) ? 1 : int'(shape_cfg.one_min);
      hi = int'(shape_cfg.end_min) - 1;
    end else begin
      lo = 1;
      hi = int'(shape_cfg.one_min) - 1;
    end
    if (hi < lo) hi = lo;
    if (tight) return one ? lo : hi;
    return int'($urandom_range(hi, lo));
  endfunction

  // Low leader followed by a short high leader space.
  task automatic open_frame(input int lows);
    if (lows < 1) lows = 1;
    send_run(1'b0, lows);
    send_run(1'b1, $urandom_range(3, 1));
  endtask

  // Bits go out first bit first: a mark, then a space whose length gives the bit.
  task automatic send_bits(input logic [BYTE_W-1:0] value, input int nbits, input bit tight);
    int b;
    for (b = 0; b < nbits; b++) begin
      send_run(1'b0, tight ? 1 : $urandom_range(2, 1));
      send_run(1'b1, space_ticks(value[b], tight));
    end
  endtask

  // A final mark, then a space just long enough to close the frame.
  task automatic send_end_space();
    send_run(1'b0, 1);
    send_run(1'b1, (shape_cfg.end_min == 0) ? 1 : int'(shape_cfg.end_min));
  endtask

  // Drop valid, wait until every predicted word has been taken, then let the block finish
  // any sample that makes no word.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A setup phase, then an access phase held until pready, then the port is released. The upper data
  // bits carry noise that the block must ignore.
  task automatic write_reg(input reg_idx_e idx, input logic [COUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_LEADER_MIN: shape_cfg.leader_min = value;
      REG_ONE_MIN:    shape_cfg.one_min    = value;
      REG_END_MIN:    shape_cfg.end_min    = value;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [COUNT_W-1:0] leader_min,
                                input logic [COUNT_W-1:0] one_min,
                                input logic [COUNT_W-1:0] end_min);
    wait_drained();
    write_reg(REG_LEADER_MIN, leader_min);
    write_reg(REG_ONE_MIN, one_min);
    write_reg(REG_END_MIN, end_min);
  endtask

  initial begin : stimulus
    int frames;
    int pick;
    int one;
    bit pressed;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.ir_level = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    shape_cfg      = '{leader_min: LEADER_MIN_RST, one_min: ONE_MIN_RST, end_min: END_MIN_RST};
    frames         = 0;
    pressed        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds: a leader far too short leaves the block idle.
    send_run(1'b0, 5);
    send_run(1'b1, 1);

    // Small thresholds: both extreme bytes, with the leader exactly at its minimum.
    set_thresholds(16'd2, 16'd3, 16'd6);
    open_frame(2);
    send_bits(8'h00, 8, 1'b1);
    send_bits(8'hFF, 8, 1'b1);
    send_end_space();
    // A leader one tick short of the minimum leaves the block idle.
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    // A frame that ends after three bits keeps no byte.
    open_frame(2);
    send_bits(8'hA5, 3, 1'b0);
    send_end_space();
    // Lowering the end threshold below a running space ends the frame at the next mark.
    open_frame(3);
    send_bits(8'h3C, 8, 1'b0);
    send_run(1'b0, 1);
    send_run(1'b1, 4);
    wait_drained();
    write_reg(REG_END_MIN, 16'd3);
    send_run(1'b0, 1);

    // Zero thresholds: a one-tick leader passes and the first space tick ends the frame.
    set_thresholds(16'd0, 16'd0, 16'd0);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    // A zero bit threshold turns every space into a one.
    set_thresholds(16'd0, 16'd0, 16'd2);
    open_frame(1);
    send_bits(8'h00, 8, 1'b1);
    send_end_space();

    // More bytes than the block keeps: the last one is dropped and flagged, and the
    // next frame starts with the flag clear.
    set_thresholds(16'd1, 16'd2, 16'd3);
    open_frame(1);
    repeat (int'(MAX_BYTES) + 1) send_bits(8'h81, 8, 1'b1);
    send_end_space();
    open_frame(1);
    send_bits(8'h5A, 8, 1'b0);
    send_end_space();

    // All thresholds at their maximum: a four-tick leader falls far short.
    set_thresholds(COUNT_MAX, COUNT_MAX, COUNT_MAX);
    send_run(1'b0, 4);
    send_run(1'b1, 1);

    // Random part. The sender and receiver swap their idle rates after the first third
    // and stop idling for the last third, where the long receiver hold-off comes first.
    wait_drained();
    samples_sent = 0;
    while (samples_sent < SAMPLE_TARGET || !pressed) begin
      if (samples_sent < SAMPLE_TARGET / 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 55;
      end else if (samples_sent < 2 * SAMPLE_TARGET / 3) begin
        tx_idle_pct = 55;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (frames % 6 == 0) begin
        if ($urandom_range(3) == 0) begin
          set_thresholds(16'($urandom_range(8)), 16'($urandom_range(8)),
                         16'($urandom_range(8)));
        end else begin
          one = $urandom_range(5, 2);
          set_thresholds(16'($urandom_range(6, 1)), 16'(one),
                         16'(one + $urandom_range(6, 1)));
        end
      end
      if (tx_idle_pct == 0 && !pressed) begin
        // Thresholds that let whole bytes through, so the held word really blocks.
        pressed = 1'b1;
        set_thresholds(16'd2, 16'd3, 16'd8);
        hold_off_asked <= hold_off_asked + 1;
        open_frame(int'(shape_cfg.leader_min));
        repeat (3) send_bits(8'($urandom), 8, 1'b0);
        send_end_space();
      end
      pick = $urandom_range(9);
      case (pick)
        0: begin
          // Noise: runs of random level and length.
          repeat ($urandom_range(6, 1)) send_run(1'($urandom_range(1)), $urandom_range(6, 1));
        end
        1: begin
          // A leader that falls short, when the threshold allows one.
          send_run(1'b0, (shape_cfg.leader_min > 1) ?
                         $urandom_range(shape_cfg.leader_min - 1, 1) : 1);
          send_run(1'b1, 1);
        end
        2: begin
          // A frame that breaks off part way through a byte.
          open_frame(shape_cfg.leader_min + $urandom_range(2));
          repeat ($urandom_range(2)) send_bits(8'($urandom), 8, 1'b0);
          send_bits(8'($urandom), $urandom_range(7, 1), 1'b0);
          send_end_space();
        end
        default: begin
          open_frame(shape_cfg.leader_min + $urandom_range(2));
          repeat ($urandom_range(4)) send_bits(8'($urandom), 8, 1'b0);
          send_end_space();
        end
      endcase
      frames++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/irpd_pkg.sv
src/irpd_if.sv
src/irpd_cfg_regs.sv
src/irpd_core.sv
src/ir_pulse_distance_decoder.sv
test/irpd_frame_checker.sv
test/testbench.sv
